// ===== rtl/ttc_pkg.sv =====
package ttc_pkg;

  localparam int WINDOW  = 16;
  localparam int WIN_AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int SUM_W   = $clog2(255 * WINDOW + 1);
  localparam int SPEED_W = 8;
  localparam int ALT_W   = 15;
  localparam int TAG_W   = 32;
  localparam int LINE_W  = 24;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  localparam logic [LINE_W-1:0]  LINE_MAX      = {LINE_W{1'b1}};
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 8'd5;
  localparam logic [WIN_AW-1:0]  LAST_IDX      = WIN_AW'(WINDOW - 1);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_START = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    KIND_CLEARED = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_LINE    = 2'd2,
    KIND_STOPPED = 2'd3
  } kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } bk_state_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [TAG_W-1:0]        tag;
    logic signed [ALT_W-1:0] alt;
    logic                    any_moving;
    logic [WIN_AW-1:0]       start_slot;
  } cmd_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [TAG_W-1:0]   tag;
  } win_rd_t;

endpackage

// ===== rtl/ttc_front.sv =====
module ttc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic                      in_has_fix,
  input  logic [7:0]                in_speed_knots,
  input  logic signed [14:0]        in_altitude_m,
  input  logic [31:0]               in_record_tag,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_data,
  input  logic                      q_full,
  output logic                      q_push,
  output ttc_pkg::cmd_t             q_cmd,
  input  logic [ttc_pkg::WIN_AW-1:0] rd_slot,
  output ttc_pkg::win_rd_t          rd_data,
  input  logic                      replay_done
);

  logic [ttc_pkg::SPEED_W-1:0] spd_mem_r [ttc_pkg::WINDOW];
  logic [ttc_pkg::TAG_W-1:0]   tag_mem_r [ttc_pkg::WINDOW];

  logic [ttc_pkg::WIN_AW-1:0] wslot_r, wslot_nxt;
  logic [ttc_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [ttc_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic                       rec_r, rec_nxt;
  logic                       start_pend_r, start_pend_nxt;
  logic [ttc_pkg::SPEED_W-1:0] min_speed_r;

  logic [ttc_pkg::WIN_AW-1:0] rd_addr;
  logic [ttc_pkg::SUM_W-1:0]  thresh;
  logic                       accept, clear, sample, full, full_now, below;

  assign rd_addr       = start_pend_r ? rd_slot : wslot_r;
  assign rd_data.speed = spd_mem_r[rd_addr];
  assign rd_data.tag   = tag_mem_r[rd_addr];

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !start_pend_r;
  assign accept    = in_valid && in_ready;
  assign clear     = accept && (in_op == ttc_pkg::OP_CLEAR);
  assign sample    = accept && (in_op == ttc_pkg::OP_SAMPLE) && in_has_fix;

  assign full     = (fill_r == ttc_pkg::FILL_W'(ttc_pkg::WINDOW));
  assign full_now = full || (fill_r == ttc_pkg::FILL_W'(ttc_pkg::WINDOW - 1));
  assign thresh   = ttc_pkg::SUM_W'(min_speed_r * ttc_pkg::WINDOW);
  assign below    = (sum_nxt < thresh);

  always_comb begin
    sum_nxt   = sum_r;
    wslot_nxt = wslot_r;
    fill_nxt  = fill_r;
    if (sample) begin
      sum_nxt = sum_r - (full ? ttc_pkg::SUM_W'(rd_data.speed) : '0)
                + ttc_pkg::SUM_W'(in_speed_knots);
      wslot_nxt = (wslot_r == ttc_pkg::LAST_IDX) ? '0 : wslot_r + 1'b1;
      fill_nxt  = full ? fill_r : fill_r + 1'b1;
    end
  end

  always_comb begin
    q_push           = 1'b0;
    q_cmd.kind       = ttc_pkg::CMD_CLEAR;
    q_cmd.tag        = in_record_tag;
    q_cmd.alt        = in_altitude_m;
    q_cmd.any_moving = (sum_nxt != '0);
    q_cmd.start_slot = wslot_nxt;
    rec_nxt          = rec_r;
    start_pend_nxt   = start_pend_r && !replay_done;
    if (clear) begin
      q_push = 1'b1;
    end else if (sample && full_now) begin
      if (below) begin
        if (rec_r) begin
          q_push     = 1'b1;
          q_cmd.kind = ttc_pkg::CMD_STOP;
          rec_nxt    = 1'b0;
        end
      end else if (!rec_r) begin
        q_push         = 1'b1;
        q_cmd.kind     = ttc_pkg::CMD_START;
        rec_nxt        = 1'b1;
        start_pend_nxt = 1'b1;
      end else begin
        q_push     = 1'b1;
        q_cmd.kind = ttc_pkg::CMD_LINE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample) begin
      spd_mem_r[wslot_r] <= in_speed_knots;
      tag_mem_r[wslot_r] <= in_record_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r      <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      rec_r        <= 1'b0;
      start_pend_r <= 1'b0;
      min_speed_r  <= ttc_pkg::MIN_SPEED_RST;
    end else begin
      wslot_r      <= wslot_nxt;
      fill_r       <= fill_nxt;
      sum_r        <= sum_nxt;
      rec_r        <= rec_nxt;
      start_pend_r <= start_pend_nxt;
      if (cfg_valid && cfg_ready) begin
        min_speed_r <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/ttc_queue.sv =====
module ttc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ttc_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ttc_pkg::cmd_t pop_data
);

  ttc_pkg::cmd_t         mem_r [ttc_pkg::QDEPTH];
  logic [ttc_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ttc_pkg::QAW:0]   cnt_r;

  assign full     = (cnt_r == (ttc_pkg::QAW+1)'(ttc_pkg::QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ttc_back.sv =====
module ttc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  ttc_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic [ttc_pkg::WIN_AW-1:0] rd_slot,
  input  ttc_pkg::win_rd_t           rd_data,
  output logic                       replay_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [31:0]                out_line_tag,
  output logic [23:0]                out_lines_written,
  output logic signed [14:0]         out_peak_altitude,
  output logic                       out_results_ready,
  output logic                       out_last
);

  ttc_pkg::bk_state_t state_r, state_nxt;

  logic [ttc_pkg::WIN_AW-1:0] slot_r, slot_nxt;
  logic [ttc_pkg::WIN_AW-1:0] idx_r, idx_nxt;
  logic                       moving_r, moving_nxt;
  logic [ttc_pkg::TAG_W-1:0]  prev_tag_r, prev_tag_nxt;
  logic [ttc_pkg::LINE_W-1:0] lines_r, lines_nxt, lines_inc;
  logic signed [ttc_pkg::ALT_W-1:0] peak_r, peak_nxt;
  logic                       done_r, done_nxt;

  logic                       ov_r, ov_nxt;
  ttc_pkg::kind_t             okind_r, okind_nxt;
  logic [ttc_pkg::TAG_W-1:0]  otag_r, otag_nxt;
  logic                       olast_r, olast_nxt;
  logic [ttc_pkg::LINE_W-1:0] olines_r;
  logic signed [ttc_pkg::ALT_W-1:0] opeak_r;
  logic                       odone_r;

  logic can_emit, at_end, emit_cur, emit_prev, skip;

  assign can_emit  = !ov_r || out_ready;
  assign q_pop     = (state_r == ttc_pkg::BK_IDLE) && q_valid && can_emit;
  assign rd_slot   = slot_r;
  assign at_end    = (idx_r == ttc_pkg::LAST_IDX);
  assign lines_inc = (lines_r == ttc_pkg::LINE_MAX) ? lines_r : lines_r + 1'b1;

  assign emit_cur  = moving_r || ((rd_data.speed != '0) && (idx_r == '0));
  assign emit_prev = !moving_r && (rd_data.speed != '0) && (idx_r != '0);
  assign skip      = !moving_r && (rd_data.speed == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ttc_pkg::BK_IDLE: begin
        if (q_pop && (q_cmd.kind == ttc_pkg::CMD_START) && q_cmd.any_moving) begin
          state_nxt = ttc_pkg::BK_SCAN;
        end
      end
      ttc_pkg::BK_SCAN: begin
        if (can_emit && at_end && (emit_cur || skip)) begin
          state_nxt = ttc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = ttc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    slot_nxt     = slot_r;
    idx_nxt      = idx_r;
    moving_nxt   = moving_r;
    prev_tag_nxt = prev_tag_r;
    lines_nxt    = lines_r;
    peak_nxt     = peak_r;
    done_nxt     = done_r;
    replay_done  = 1'b0;
    ov_nxt       = ov_r && !out_ready;
    okind_nxt    = okind_r;
    otag_nxt     = otag_r;
    olast_nxt    = olast_r;
    case (state_r)
      ttc_pkg::BK_IDLE: begin
        if (q_pop) begin
          ov_nxt    = 1'b1;
          otag_nxt  = '0;
          olast_nxt = 1'b1;
          case (q_cmd.kind)
            ttc_pkg::CMD_CLEAR: begin
              okind_nxt = ttc_pkg::KIND_CLEARED;
              lines_nxt = '0;
              peak_nxt  = '0;
              done_nxt  = 1'b0;
            end
            ttc_pkg::CMD_STOP: begin
              okind_nxt = ttc_pkg::KIND_STOPPED;
              done_nxt  = 1'b1;
            end
            ttc_pkg::CMD_LINE: begin
              okind_nxt = ttc_pkg::KIND_LINE;
              otag_nxt  = q_cmd.tag;
              lines_nxt = lines_inc;
              if (q_cmd.alt > peak_r) begin
                peak_nxt = q_cmd.alt;
              end
            end
            ttc_pkg::CMD_START: begin
              okind_nxt   = ttc_pkg::KIND_HEADER;
              olast_nxt   = !q_cmd.any_moving;
              replay_done = !q_cmd.any_moving;
              slot_nxt    = q_cmd.start_slot;
              idx_nxt     = '0;
              moving_nxt  = 1'b0;
            end
            default: okind_nxt = ttc_pkg::KIND_CLEARED;
          endcase
        end
      end
      ttc_pkg::BK_SCAN: begin
        if (can_emit) begin
          if (emit_prev) begin
            moving_nxt = 1'b1;
            lines_nxt  = lines_inc;
            ov_nxt     = 1'b1;
            okind_nxt  = ttc_pkg::KIND_LINE;
            otag_nxt   = prev_tag_r;
            olast_nxt  = 1'b0;
          end else begin
            if (emit_cur) begin
              moving_nxt = 1'b1;
              lines_nxt  = lines_inc;
              ov_nxt     = 1'b1;
              okind_nxt  = ttc_pkg::KIND_LINE;
              otag_nxt   = rd_data.tag;
              olast_nxt  = at_end;
            end
            prev_tag_nxt = rd_data.tag;
            if (at_end) begin
              replay_done = 1'b1;
            end else begin
              idx_nxt  = idx_r + 1'b1;
              slot_nxt = (slot_r == ttc_pkg::LAST_IDX) ? '0 : slot_r + 1'b1;
            end
          end
        end
      end
      default: replay_done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
    prev_tag_r <= prev_tag_nxt;
    okind_r    <= okind_nxt;
    otag_r     <= otag_nxt;
    olast_r    <= olast_nxt;
    if (ov_nxt && !(ov_r && !out_ready)) begin
      olines_r <= lines_nxt;
      opeak_r  <= peak_nxt;
      odone_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ttc_pkg::BK_IDLE;
      moving_r <= 1'b0;
      lines_r  <= '0;
      peak_r   <= '0;
      done_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      moving_r <= moving_nxt;
      lines_r  <= lines_nxt;
      peak_r   <= peak_nxt;
      done_r   <= done_nxt;
      ov_r     <= ov_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_kind          = okind_r;
  assign out_line_tag      = otag_r;
  assign out_lines_written = olines_r;
  assign out_peak_altitude = opeak_r;
  assign out_results_ready = odone_r;
  assign out_last          = olast_r;

endmodule

// ===== rtl/takeoff_triggered_track_capture_unit.sv =====
// channel   direction  handshake             word
// in_*      input      in_valid / in_ready   op, fix, speed, altitude, tag
// out_*     output     out_valid / out_ready kind, tag, lines, peak, ready, last
// cfg_*     input      cfg_valid / cfg_ready min_speed write data
//
// A clear, stop or track-line word leaves the back end as a single output word.
// A takeoff yields a header word, then any line words replayed from the window;
// input stalls during the replay. The front end accepts one word per cycle
// while the 4-entry command queue has room and no takeoff replay is pending.
// Reset is synchronous, active low; window contents are not reset.
module takeoff_triggered_track_capture_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic               in_has_fix,
  input  logic [7:0]         in_speed_knots,
  input  logic signed [14:0] in_altitude_m,
  input  logic [31:0]        in_record_tag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [31:0]        out_line_tag,
  output logic [23:0]        out_lines_written,
  output logic signed [14:0] out_peak_altitude,
  output logic               out_results_ready,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  ttc_pkg::cmd_t              push_cmd, pop_cmd;
  ttc_pkg::win_rd_t           rd_data;
  logic [ttc_pkg::WIN_AW-1:0] rd_slot;
  logic                       q_full, q_push, q_pop, q_valid, replay_done;

  ttc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_has_fix     (in_has_fix),
    .in_speed_knots (in_speed_knots),
    .in_altitude_m  (in_altitude_m),
    .in_record_tag  (in_record_tag),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd),
    .rd_slot        (rd_slot),
    .rd_data        (rd_data),
    .replay_done    (replay_done)
  );

  ttc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_cmd)
  );

  ttc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (pop_cmd),
    .q_pop             (q_pop),
    .rd_slot           (rd_slot),
    .rd_data           (rd_data),
    .replay_done       (replay_done),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_line_tag      (out_line_tag),
    .out_lines_written (out_lines_written),
    .out_peak_altitude (out_peak_altitude),
    .out_results_ready (out_results_ready),
    .out_last          (out_last)
  );

endmodule

// ===== rtl/ttc_checker.sv =====
module ttc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic [31:0]        out_line_tag,
  input logic [23:0]        out_lines_written,
  input logic signed [14:0] out_peak_altitude,
  input logic               out_results_ready,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_line_tag)
      && $stable(out_last))
    else $error("output word changed while stalled");

  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != ttc_pkg::KIND_LINE) |-> out_line_tag == '0)
    else $error("non-line word carries a tag");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == ttc_pkg::KIND_CLEARED) |->
      out_lines_written == '0 && out_peak_altitude == '0 && !out_results_ready && out_last)
    else $error("clear word shows stale summary");

  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == ttc_pkg::KIND_STOPPED) |-> out_results_ready && out_last)
    else $error("stop word without results ready");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind takeoff_triggered_track_capture_unit ttc_checker u_ttc_checker (.*);

// ===== test/track_capture_checker.sv =====
`timescale 1ns / 1ps

module track_capture_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_op,
  input  logic               in_has_fix,
  input  logic [7:0]         in_speed_knots,
  input  logic signed [14:0] in_altitude_m,
  input  logic [31:0]        in_record_tag,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_kind,
  input  logic [31:0]        out_line_tag,
  input  logic [23:0]        out_lines_written,
  input  logic signed [14:0] out_peak_altitude,
  input  logic               out_results_ready,
  input  logic               out_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 mismatches,
  output int                 words_due
);

  typedef struct packed {
    ttc_pkg::kind_t          kind;
    logic [31:0]             tag;
    logic [23:0]             lines;
    logic signed [14:0]      peak;
    logic                    done;
    logic                    last;
  } capture_word_t;

  capture_word_t due_words[$];
  capture_word_t held_word;
  bit            have_held;

  logic [7:0]         win_speed [ttc_pkg::WINDOW];
  logic [31:0]        win_tag   [ttc_pkg::WINDOW];
  int                 head;
  int                 filled;
  int                 speed_sum;
  bit                 airborne;
  logic [23:0]        line_cnt;
  logic signed [14:0] peak_alt;
  bit                 flight_over;
  logic [7:0]         min_knots;

  task automatic emit_word(input ttc_pkg::kind_t k, input logic [31:0] tag);
    capture_word_t w;
    w.kind  = k;
    w.tag   = tag;
    w.lines = line_cnt;
    w.peak  = peak_alt;
    w.done  = flight_over;
    w.last  = 1'b0;
    if (have_held) due_words.push_back(held_word);
    held_word = w;
    have_held = 1'b1;
  endtask

  task automatic count_line();
    if (line_cnt != ttc_pkg::LINE_MAX) line_cnt = line_cnt + 24'd1;
  endtask

  task automatic predict_capture(input logic op, input logic fix, input logic [7:0] spd,
                                 input logic signed [14:0] alt, input logic [31:0] tag);
    int  slot;
    bit  moving;
    moving = 1'b0;
    if (op == ttc_pkg::OP_CLEAR) begin
      line_cnt    = '0;
      peak_alt    = '0;
      flight_over = 1'b0;
      emit_word(ttc_pkg::KIND_CLEARED, '0);
    end else if (fix) begin
      if (filled >= ttc_pkg::WINDOW) speed_sum -= int'(win_speed[head]);
      win_speed[head] = spd;
      win_tag[head]   = tag;
      speed_sum += int'(spd);
      head = (head + 1) % ttc_pkg::WINDOW;
      if (filled < ttc_pkg::WINDOW) filled++;
      if (filled == ttc_pkg::WINDOW) begin
        if (speed_sum < int'(min_knots) * ttc_pkg::WINDOW) begin
          if (airborne) begin
            airborne    = 1'b0;
            flight_over = 1'b1;
            emit_word(ttc_pkg::KIND_STOPPED, '0);
          end
        end else if (!airborne) begin
          airborne = 1'b1;
          emit_word(ttc_pkg::KIND_HEADER, '0);
          for (int i = 0; i < ttc_pkg::WINDOW; i++) begin
            slot = (head + i) % ttc_pkg::WINDOW;
            if (!moving && win_speed[slot] != 8'd0) begin
              moving = 1'b1;
              if (i > 0) begin
                count_line();
                emit_word(ttc_pkg::KIND_LINE, win_tag[(head + i - 1) % ttc_pkg::WINDOW]);
              end
            end
            if (moving) begin
              count_line();
              emit_word(ttc_pkg::KIND_LINE, win_tag[slot]);
            end
          end
        end else begin
          count_line();
          if (alt > peak_alt) peak_alt = alt;
          emit_word(ttc_pkg::KIND_LINE, tag);
        end
      end
    end
    if (have_held) begin
      held_word.last = 1'b1;
      due_words.push_back(held_word);
      have_held = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    capture_word_t w;
    if (!rst_n) begin
      due_words.delete();
      have_held   = 1'b0;
      head        = 0;
      filled      = 0;
      speed_sum   = 0;
      airborne    = 1'b0;
      line_cnt    = '0;
      peak_alt    = '0;
      flight_over = 1'b0;
      min_knots   = ttc_pkg::MIN_SPEED_RST;
      mismatches  = 0;
    end else begin
      if (cfg_valid && cfg_ready) min_knots = cfg_data;
      if (in_valid && in_ready)
        predict_capture(in_op, in_has_fix, in_speed_knots, in_altitude_m, in_record_tag);
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $error("unexpected word: kind %0d tag %0h", out_kind, out_line_tag);
          mismatches++;
        end else begin
          w = due_words.pop_front();
          check_field("kind", longint'(w.kind), longint'(out_kind));
          check_field("line_tag", longint'(w.tag), longint'(out_line_tag));
          check_field("lines_written", longint'(w.lines), longint'(out_lines_written));
          check_field("peak_altitude", longint'(w.peak), longint'(out_peak_altitude));
          check_field("results_ready", longint'(w.done), longint'(out_results_ready));
          check_field("last", longint'(w.last), longint'(out_last));
        end
      end
    end
    words_due <= due_words.size();
  end

endmodule

// ===== test/tb_takeoff_triggered_track_capture_unit.sv =====
`timescale 1ns / 1ps

module tb_takeoff_triggered_track_capture_unit;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 32;
  localparam int SETTLE       = 2 * ttc_pkg::WINDOW + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_op;
  logic               in_has_fix;
  logic [7:0]         in_speed_knots;
  logic signed [14:0] in_altitude_m;
  logic [31:0]        in_record_tag;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_kind;
  logic [31:0]        out_line_tag;
  logic [23:0]        out_lines_written;
  logic signed [14:0] out_peak_altitude;
  logic               out_results_ready;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;

  int          mismatches;
  int          words_due;
  int          words_sent;
  int          hold_requests;
  bit          calm;
  int unsigned cycle_count;

  takeoff_triggered_track_capture_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_has_fix        (in_has_fix),
    .in_speed_knots    (in_speed_knots),
    .in_altitude_m     (in_altitude_m),
    .in_record_tag     (in_record_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_line_tag      (out_line_tag),
    .out_lines_written (out_lines_written),
    .out_peak_altitude (out_peak_altitude),
    .out_results_ready (out_results_ready),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  track_capture_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_has_fix        (in_has_fix),
    .in_speed_knots    (in_speed_knots),
    .in_altitude_m     (in_altitude_m),
    .in_record_tag     (in_record_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_line_tag      (out_line_tag),
    .out_lines_written (out_lines_written),
    .out_peak_altitude (out_peak_altitude),
    .out_results_ready (out_results_ready),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .words_due         (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("takeoff_triggered_track_capture_unit test failed");
    $finish;
  end

  // receiver: random stalls, a long hold on request, none while calm
  initial begin : rx_side
    int served;
    served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  function automatic logic signed [14:0] rand_alt();
    int a;
    case ($urandom_range(9))
      0:       a = -1024;
      1:       a = 16383;
      default: a = int'($urandom_range(0, 17407)) - 1024;
    endcase
    return 15'(a);
  endfunction

  task automatic send_word(input ttc_pkg::op_t op, input logic fix, input logic [7:0] spd,
                           input logic signed [14:0] alt, input logic [31:0] tag);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_has_fix     <= fix;
    in_speed_knots <= spd;
    in_altitude_m  <= alt;
    in_record_tag  <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == ttc_pkg::OP_CLEAR || fix) words_sent++;
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_clear();
    send_word(ttc_pkg::OP_CLEAR, 1'($urandom_range(1)), 8'($urandom), rand_alt(), $urandom);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_min_speed(input logic [7:0] knots);
    cfg_valid <= 1'b1;
    cfg_data  <= knots;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one leg of a flight, with dropped fixes and clears mixed in
  task automatic fly_leg(input int count, input int lo, input int hi, input int zero_pct);
    logic [7:0] spd;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 6)
        send_word(ttc_pkg::OP_SAMPLE, 1'b0, 8'($urandom), rand_alt(), $urandom);
      else if ($urandom_range(99) < 2)
        send_clear();
      spd = ($urandom_range(99) < zero_pct) ? 8'd0 : 8'($urandom_range(lo, hi));
      send_word(ttc_pkg::OP_SAMPLE, 1'b1, spd, rand_alt(), $urandom);
    end
  endtask

  task automatic fly(input int thr);
    int air_hi;
    air_hi = (thr * 3 + 10 > 255) ? 255 : thr * 3 + 10;
    fly_leg($urandom_range(2, 20), 0, (thr > 1) ? thr - 1 : 0, 60);
    fly_leg($urandom_range(8, 40), thr, air_hi, 0);
    fly_leg($urandom_range(4, 22), 0, thr / 2, 50);
  endtask

  initial begin : stimulus
    logic [7:0] plan [PHASES];
    int         phase_start;
    bit         paused;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_op          <= ttc_pkg::OP_SAMPLE;
    in_has_fix     <= 1'b0;
    in_speed_knots <= '0;
    in_altitude_m  <= '0;
    in_record_tag  <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    words_sent     = 0;
    hold_requests  = 0;
    calm           = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_clear();
    send_word(ttc_pkg::OP_SAMPLE, 1'b0, 8'd255, 15'sd16383, 32'hFFFF_FFFF);
    // fill to a speed sum of exactly the threshold, two still samples first
    for (int i = 0; i < ttc_pkg::WINDOW; i++)
      send_word(ttc_pkg::OP_SAMPLE, 1'b1,
                (i < 2) ? 8'd0 : (i == ttc_pkg::WINDOW - 1) ? 8'd15 : 8'd5,
                15'(i * 100 - 1024), 32'h0000_0100 + 32'(i));
    send_word(ttc_pkg::OP_SAMPLE, 1'b1, 8'd5, 15'sd16383, 32'hFFFF_FFFF);
    send_word(ttc_pkg::OP_SAMPLE, 1'b1, 8'd0, -15'sd1024, 32'h0000_0000);
    send_clear();
    send_word(ttc_pkg::OP_SAMPLE, 1'b0, 8'd0, 15'sd0, 32'h0000_0200);
    send_word(ttc_pkg::OP_SAMPLE, 1'b1, 8'd0, 15'sd100, 32'h0000_0201);
    send_word(ttc_pkg::OP_SAMPLE, 1'b1, 8'd0, -15'sd1, 32'h0000_0202);
    send_word(ttc_pkg::OP_SAMPLE, 1'b1, 8'd255, 15'sd200, 32'h0000_0203);

    plan[0] = 8'($urandom_range(2, 12));
    plan[1] = 8'd0;
    plan[2] = 8'd255;
    plan[3] = 8'($urandom_range(1, 40));
    plan[4] = 8'd1;
    plan[5] = 8'($urandom_range(0, 255));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      set_min_speed(plan[ph]);
      calm        = (ph == 3);
      phase_start = words_sent;
      paused      = 1'b0;
      while (words_sent - phase_start < PHASE_ITEMS) begin
        // stall the output while every sample makes a line
        if (plan[ph] == 8'd0 && hold_requests == 0)
          hold_requests++;
        if ($urandom_range(99) < 75) begin
          fly(int'(plan[ph]));
        end else begin
          repeat ($urandom_range(3, 12)) begin
            if ($urandom_range(99) < 5) send_clear();
            else send_word(ttc_pkg::OP_SAMPLE, 1'($urandom_range(1)), 8'($urandom),
                           rand_alt(), $urandom);
          end
        end
        if (ph == 2 && !paused && words_sent - phase_start > PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end
    calm = 1'b0;
    wait_idle();

    if (mismatches == 0 && words_due == 0)
      $display("takeoff_triggered_track_capture_unit test passed");
    else
      $display("takeoff_triggered_track_capture_unit test failed");
    $finish;
  end

endmodule

// ===== takeoff_triggered_track_capture_unit.f =====
rtl/ttc_pkg.sv
rtl/ttc_front.sv
rtl/ttc_queue.sv
rtl/ttc_back.sv
rtl/takeoff_triggered_track_capture_unit.sv
rtl/ttc_checker.sv
test/track_capture_checker.sv
test/tb_takeoff_triggered_track_capture_unit.sv
